// ===== sv/cuc_pkg.sv =====
`default_nettype none

package cuc_pkg;

    // Field widths fixed by the cell format.
    localparam int COL_W   = 4;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 13;

    // Row limit after reset.
    localparam logic [ROW_W-1:0] ROW_LIMIT_RESET = 13'd4096;

    // Multiplicative hash constant; the product is kept to 32 bits.
    localparam logic [VALUE_W-1:0] HASH_MULT = 32'd2654435761;

    // Generation tag kept with every slot. A slot is occupied only when its tag
    // equals the current generation. Tag zero is never a live generation.
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic empty;
        logic match;
    } t_probe_res;

endpackage

`default_nettype wire

// ===== sv/cuc_slot_store.sv =====
`default_nettype none

module cuc_slot_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [ADDR_W-1:0]           i_waddr,
    input  wire cuc_pkg::t_slot              i_wdata,
    input  wire logic [ADDR_W-1:0]           i_raddr,
    input  wire logic [cuc_pkg::EPOCH_W-1:0] i_epoch,
    input  wire logic [cuc_pkg::VALUE_W-1:0] i_value,
    output cuc_pkg::t_probe_res              o_res
);
    import cuc_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // A slot from an older generation counts as empty.
    assign o_res.empty = (r_rdata.epoch != i_epoch);
    assign o_res.match = (r_rdata.epoch == i_epoch) && (r_rdata.value == i_value);

endmodule

`default_nettype wire

// ===== sv/column_uniqueness_classifier.sv =====
`default_nettype none
// From accept, a cell is evaluated, hashed, reduced modulo ROWS_MAX when ROWS_MAX is not a
// power of two, and probed linearly until an empty slot, a match or a full region; nulls,
// ignored cells and columns already non-key finish at evaluation. It takes one cell per
// busy period; the one-read-port slot memory sets the probe rate. Reset (synchronous,
// active low) starts a clear of all COLUMNS*ROWS_MAX slots; busy is high until it ends.
// The clear recurs on every 255th start with i_start_req set. Results cannot be stalled.

module column_uniqueness_classifier #(
    parameter int COLUMNS  = 16,
    parameter int ROWS_MAX = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic                        i_start_req,
    input  wire logic [cuc_pkg::COL_W-1:0]   i_column,
    input  wire logic [cuc_pkg::VALUE_W-1:0] i_cell_value,
    input  wire logic                        i_is_null,
    input  wire logic                        i_row_end,
    input  wire logic                        i_cfg_we,
    input  wire logic [cuc_pkg::ROW_W-1:0]   i_cfg_wdata,
    output      logic                        o_valid,
    output      logic [cuc_pkg::COL_W-1:0]   o_out_column,
    output      logic                        o_key_class,
    output      logic                        o_ignored
);
    import cuc_pkg::*;

    // Each column owns a region of ROWS_MAX slots in one shared memory.
    localparam int SLOTS  = COLUMNS * ROWS_MAX;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(ROWS_MAX);
    localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CEXT_W = 9;
    localparam int LIM_W  = 17;
    localparam bit IS_POW2 = ((ROWS_MAX & (ROWS_MAX - 1)) == 0);

    // Reciprocal of ROWS_MAX scaled by 2^(VALUE_W + POS_W), rounded down.
    localparam int RECIP_W = VALUE_W + 1;
    localparam int RSH     = VALUE_W + POS_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RSH) / 64'(ROWS_MAX));

    localparam logic [CEXT_W-1:0] COLS_L     = CEXT_W'(COLUMNS);
    localparam logic [LIM_W-1:0]  ROWS_L     = LIM_W'(ROWS_MAX);
    localparam logic [POS_W:0]    ROWS_P     = (POS_W + 1)'(ROWS_MAX);
    localparam logic [VALUE_W-1:0] ROWS_V    = VALUE_W'(ROWS_MAX);
    localparam logic [POS_W:0]    PROBE_LAST = (POS_W + 1)'(ROWS_MAX - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(SLOTS - 1);
    localparam logic [ADDR_W-1:0] ROWS_A     = ADDR_W'(ROWS_MAX);
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_HASH  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_PROBE = 3'd5;
    localparam logic [2:0] S_CHECK = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [ROW_W-1:0]    r_row_limit, n_row_limit;
    logic [ROW_W-1:0]    r_rows_done, n_rows_done;
    logic [COLUMNS-1:0]  r_class, n_class;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_pending, n_pending;

    // Cell under work.
    logic [COL_W-1:0]    r_col, n_col;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                r_is_null, n_is_null;
    logic                r_row_end, n_row_end;

    // Hash and probe datapath.
    logic [VALUE_W-1:0]  r_prod, n_prod;
    logic [VALUE_W-1:0]  r_quo, n_quo;
    logic [1:0]          r_step, n_step;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W:0]      r_probes, n_probes;
    logic [ADDR_W-1:0]   r_base, n_base;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic                r_out_class, n_out_class;
    logic                r_out_ign, n_out_ign;

    logic [CEXT_W-1:0]   col_ext;
    logic [CIDX_W-1:0]   col_idx;
    logic                col_ok;
    logic                in_rows;
    logic                cur_class;
    logic [VALUE_W+RECIP_W-1:0] recip_prod;
    logic [VALUE_W-1:0]  quo_mul;
    logic [VALUE_W-1:0]  red_sub;
    logic [POS_W:0]      pos_inc;
    logic [ADDR_W-1:0]   probe_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_slot               mem_wdata;
    t_probe_res          probe_res;

    assign col_ext   = {{(CEXT_W - COL_W){1'b0}}, r_col};
    assign col_idx   = col_ext[CIDX_W-1:0];
    assign col_ok    = (col_ext < COLS_L);
    assign cur_class = col_ok ? r_class[col_idx] : 1'b0;

    // The effective limit is the smaller of the register and ROWS_MAX.
    assign in_rows = (r_rows_done < r_row_limit)
                  && ({{(LIM_W - ROW_W){1'b0}}, r_rows_done} < ROWS_L);

    // Hash reduction modulo ROWS_MAX, one step per cycle.
    assign recip_prod = r_prod * RECIP;
    assign quo_mul    = r_quo * ROWS_V;
    assign red_sub    = r_prod - ROWS_V;

    assign pos_inc    = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign probe_addr = r_base + ADDR_W'(r_pos);

    always_comb begin
        n_state     = r_state;
        n_row_limit = r_row_limit;
        n_rows_done = r_rows_done;
        n_class     = r_class;
        n_epoch     = r_epoch;
        n_clr_addr  = r_clr_addr;
        n_pending   = r_pending;
        n_col       = r_col;
        n_value     = r_value;
        n_is_null   = r_is_null;
        n_row_end   = r_row_end;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_step      = r_step;
        n_pos       = r_pos;
        n_probes    = r_probes;
        n_base      = r_base;
        n_out_valid = 1'b0;
        n_out_col   = r_out_col;
        n_out_class = r_out_class;
        n_out_ign   = r_out_ign;
        mem_we      = 1'b0;
        mem_waddr   = probe_addr;
        mem_wdata   = '{epoch: r_epoch, value: r_value};

        if (i_cfg_we) begin
            n_row_limit = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_col     = i_column;
                    n_value   = i_cell_value;
                    n_is_null = i_is_null;
                    n_row_end = i_row_end;
                    n_state   = S_EVAL;
                    if (i_start_req) begin
                        n_class     = '0;
                        n_rows_done = '0;
                        // A new generation empties every set at once. When the tag
                        // would wrap, stale tags are swept out first.
                        if (r_epoch == '1) begin
                            n_epoch    = EPOCH_FIRST;
                            n_clr_addr = '0;
                            n_pending  = 1'b1;
                            n_state    = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_FIRST;
                        end
                    end
                end
            end

            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '{epoch: '0, value: r_value};
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_LAST) begin
                    n_pending = 1'b0;
                    n_state   = r_pending ? S_EVAL : S_IDLE;
                end
            end

            S_EVAL: begin
                n_out_col = r_col;
                n_base    = ADDR_W'(col_idx) * ROWS_A;
                n_prod    = VALUE_W'(r_value * HASH_MULT);
                if (in_rows && r_row_end) begin
                    n_rows_done = r_rows_done + ROW_W'(1);
                end
                if (!col_ok || !in_rows) begin
                    n_out_valid = 1'b1;
                    n_out_class = cur_class;
                    n_out_ign   = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_is_null || cur_class) begin
                    // A non-key column stays non-key, so its set need not grow.
                    n_class[col_idx] = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out_class      = 1'b1;
                    n_out_ign        = 1'b0;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_HASH;
                end
            end

            S_HASH: begin
                n_probes = '0;
                if (IS_POW2) begin
                    n_pos   = r_prod[POS_W-1:0];
                    n_state = S_PROBE;
                end else begin
                    n_step  = '0;
                    n_state = S_MOD;
                end
            end

            S_MOD: begin
                // The reciprocal product gives a quotient at most one short, so the
                // residue after the back-subtraction is below twice ROWS_MAX and one
                // compare and subtract finishes the reduction.
                n_step = r_step + 2'd1;
                if (r_step == 2'd0) begin
                    n_quo = VALUE_W'(recip_prod >> RSH);
                end else if (r_step == 2'd1) begin
                    n_prod = r_prod - quo_mul;
                end else begin
                    if (r_prod >= ROWS_V) begin
                        n_pos = red_sub[POS_W-1:0];
                    end else begin
                        n_pos = r_prod[POS_W-1:0];
                    end
                    n_state = S_PROBE;
                end
            end

            S_PROBE: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_out_ign = 1'b0;
                if (probe_res.empty) begin
                    mem_we      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_class = 1'b0;
                    n_state     = S_IDLE;
                end else if (probe_res.match || (r_probes == PROBE_LAST)) begin
                    // Either a repeat, or the region is full and uniqueness is lost.
                    n_class[col_idx] = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out_class      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_probes = r_probes + (POS_W + 1)'(1);
                    if (pos_inc == ROWS_P) begin
                        n_pos = '0;
                    end else begin
                        n_pos = pos_inc[POS_W-1:0];
                    end
                    n_state = S_PROBE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row_limit <= ROW_LIMIT_RESET;
            r_rows_done <= '0;
            r_class     <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_clr_addr  <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_limit <= n_row_limit;
            r_rows_done <= n_rows_done;
            r_class     <= n_class;
            r_epoch     <= n_epoch;
            r_clr_addr  <= n_clr_addr;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_value     <= n_value;
        r_is_null   <= n_is_null;
        r_row_end   <= n_row_end;
        r_prod      <= n_prod;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_pos       <= n_pos;
        r_probes    <= n_probes;
        r_base      <= n_base;
        r_out_col   <= n_out_col;
        r_out_class <= n_out_class;
        r_out_ign   <= n_out_ign;
    end

    // The read address is held from the probe cycle into the check cycle.
    cuc_slot_store #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (probe_addr),
        .i_epoch (r_epoch),
        .i_value (r_value),
        .o_res   (probe_res)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_out_column = r_out_col;
    assign o_key_class  = r_out_class;
    assign o_ignored    = r_out_ign;

endmodule

`default_nettype wire
